FILE: src/hysteresis_segment_detector_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hysteresis segment detector
// ---------------------------------------------------------------------------
`ifndef HYSTERESIS_SEGMENT_DETECTOR_MACROS_SVH
`define HYSTERESIS_SEGMENT_DETECTOR_MACROS_SVH

// Concurrent implication checked on every clock edge, off during reset
`define HSD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same, without a reset qualifier (for checks that hold in reset too)
`define HSD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/hsd_pkg.sv
// ---------------------------------------------------------------------------
// hsd_pkg
// Shared types, constants and helper functions of the segment detector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsd_pkg;

  localparam int unsigned LevelW = 10;
  localparam int unsigned MinRunW = 16;
  localparam int unsigned RunW = 17;
  localparam int unsigned LenW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0] LevelLowRst = LevelW'(100);
  localparam logic [LevelW-1:0] LevelHighRst = LevelW'(500);
  localparam logic [MinRunW-1:0] MinRunRst = MinRunW'(10);

  localparam logic [RunW-1:0] RunMax = '1;
  localparam logic [LenW-1:0] LenMax = '1;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEVEL_LOW = 2'd0,
    CFG_LEVEL_HIGH = 2'd1,
    CFG_MIN_LOW_RUN = 2'd2,
    CFG_MIN_HIGH_RUN = 2'd3
  } hsd_cfg_idx_e;

  // Event codes of a result word
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_BEGIN = 2'd1,
    EV_END = 2'd2
  } hsd_event_e;

  typedef struct packed {
    logic [LevelW-1:0] level_low;
    logic [LevelW-1:0] level_high;
    logic [MinRunW-1:0] min_low_run;
    logic [MinRunW-1:0] min_high_run;
  } hsd_cfg_t;

  typedef struct packed {
    hsd_event_e ev;
    logic [CountW-1:0] piece_number;
    logic [LenW-1:0] span_length;
    logic active;
  } hsd_res_t;

  // Run counter increment, saturating
  function automatic logic [RunW-1:0] run_inc(input logic [RunW-1:0] r);
    return (r == RunMax) ? RunMax : r + RunW'(1);
  endfunction

  // Length increment, saturating
  function automatic logic [LenW-1:0] len_inc(input logic [LenW-1:0] l);
    return (l == LenMax) ? LenMax : l + LenW'(1);
  endfunction

  // Remove a run from a length, floor at zero
  function automatic logic [LenW-1:0] sat_sub(input logic [LenW-1:0] a,
                                              input logic [RunW-1:0] b);
    logic [LenW-1:0] bx;
    bx = LenW'(b);
    return (a > bx) ? a - bx : '0;
  endfunction

endpackage

`default_nettype wire

FILE: src/hsd_cfg_regs.sv
// ---------------------------------------------------------------------------
// hsd_cfg_regs
// Threshold and debounce registers, written through a plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hsd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [hsd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output hsd_pkg::hsd_cfg_t               cfg_o
);
  import hsd_pkg::*;

  hsd_cfg_t cfg_q;

  // Register file, one write a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_low <= LevelLowRst;
      cfg_q.level_high <= LevelHighRst;
      cfg_q.min_low_run <= MinRunRst;
      cfg_q.min_high_run <= MinRunRst;
    end else if (cfg_we_i) begin
      unique case (hsd_cfg_idx_e'(cfg_index_i))
        CFG_LEVEL_LOW: cfg_q.level_low <= cfg_wdata_i[LevelW-1:0];
        CFG_LEVEL_HIGH: cfg_q.level_high <= cfg_wdata_i[LevelW-1:0];
        CFG_MIN_LOW_RUN: cfg_q.min_low_run <= cfg_wdata_i[MinRunW-1:0];
        CFG_MIN_HIGH_RUN: cfg_q.min_high_run <= cfg_wdata_i[MinRunW-1:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/hsd_core.sv
// ---------------------------------------------------------------------------
// hsd_core
// Segment state and the per-sample update: hysteresis, debounce, lengths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hysteresis_segment_detector_macros.svh"

module hsd_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_en_i,
  input  logic [hsd_pkg::LevelW-1:0]  level_i,
  input  hsd_pkg::hsd_cfg_t           cfg_i,
  output hsd_pkg::hsd_res_t           res_o
);
  import hsd_pkg::*;

  logic              in_piece_q, in_piece_d;
  logic [RunW-1:0]   high_run_q, high_run_d;
  logic [RunW-1:0]   low_run_q, low_run_d;
  logic [LenW-1:0]   piece_len_q, piece_len_d;
  logic [LenW-1:0]   pause_len_q, pause_len_d;
  logic [CountW-1:0] piece_cnt_q, piece_cnt_d;

  logic [RunW-1:0]   run_new;
  logic [CountW-1:0] cnt_inc;

  assign cnt_inc = piece_cnt_q + CountW'(1);

  // Per-sample update
  always_comb begin
    in_piece_d = in_piece_q;
    high_run_d = high_run_q;
    low_run_d = low_run_q;
    piece_len_d = piece_len_q;
    pause_len_d = pause_len_q;
    piece_cnt_d = piece_cnt_q;
    res_o.ev = EV_NONE;
    res_o.piece_number = '0;
    res_o.span_length = '0;
    run_new = '0;

    if (in_piece_q) begin
      // inside a piece: count low samples
      run_new = (level_i <= cfg_i.level_low) ? run_inc(low_run_q) : '0;
      if (run_new > RunW'(cfg_i.min_low_run)) begin
        pause_len_d = LenW'(run_new);
        piece_len_d = sat_sub(piece_len_q, run_new);
        low_run_d = '0;
        in_piece_d = 1'b0;
        piece_cnt_d = cnt_inc;
        res_o.ev = EV_END;
        res_o.piece_number = cnt_inc;
        res_o.span_length = piece_len_d;
      end else begin
        low_run_d = run_new;
        piece_len_d = len_inc(piece_len_q);
      end
    end else begin
      // in a pause: count high samples
      run_new = (level_i >= cfg_i.level_high) ? run_inc(high_run_q) : '0;
      if (run_new > RunW'(cfg_i.min_high_run)) begin
        piece_len_d = LenW'(run_new);
        pause_len_d = sat_sub(pause_len_q, run_new);
        high_run_d = '0;
        in_piece_d = 1'b1;
        res_o.ev = EV_BEGIN;
        res_o.piece_number = cnt_inc;
        res_o.span_length = pause_len_d;
      end else begin
        high_run_d = run_new;
        pause_len_d = len_inc(pause_len_q);
      end
    end

    res_o.active = in_piece_d;
  end

  // State registers, advanced once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_piece_q <= 1'b0;
      high_run_q <= '0;
      low_run_q <= '0;
      piece_len_q <= '0;
      pause_len_q <= '0;
      piece_cnt_q <= '0;
    end else if (step_en_i) begin
      in_piece_q <= in_piece_d;
      high_run_q <= high_run_d;
      low_run_q <= low_run_d;
      piece_len_q <= piece_len_d;
      pause_len_q <= pause_len_d;
      piece_cnt_q <= piece_cnt_d;
    end
  end

  // Only the run of the current phase may be non-zero
  `HSD_ASSERT_ALWAYS(a_low_run_idle, clk_i, (!in_piece_q) |-> (low_run_q == '0), "low run in pause")
  `HSD_ASSERT_ALWAYS(a_high_run_act, clk_i, in_piece_q |-> (high_run_q == '0), "high run in piece")
  `HSD_ASSERT(a_begin_enters, clk_i, rst_ni, (step_en_i && res_o.ev == EV_BEGIN) |=> in_piece_q, "begin without entering piece")
  `HSD_ASSERT(a_end_counts, clk_i, rst_ni, (step_en_i && res_o.ev == EV_END) |=> (piece_cnt_q == $past(cnt_inc)), "end without count")

endmodule

`default_nettype wire

FILE: src/hysteresis_segment_detector.sv
// ---------------------------------------------------------------------------
// hysteresis_segment_detector
// Piece begin/end detector on a level stream, with hysteresis and debounce.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one level sample per word (in_valid_i / in_stall_o).
//   Output channel: exactly one result word per sample (out_valid_o /
//   out_stall_i): event code, piece number, span length and active flag.
//   A word moves at a clock edge with valid high and stall low.
//   Configuration: cfg_we_i with cfg_index_i and cfg_wdata_i writes one of
//   the four threshold / debounce registers; write only while idle.
//   Path: an accepted sample is held in the input word register, and its result
//   reaches out_valid_o from the result word register (two register stages).
//   Throughput: one sample per cycle while the receiver does not stall, set by the
//   combinational state update in hsd_core between the two registers.
//   Reset: state, counters and lengths clear, registers take their reset
//   values, both pipeline stages empty.
//   Receiver stall: the result word holds; an empty input register still
//   takes one sample, and in_stall_o is high while the input register holds
//   a sample behind the waiting result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hysteresis_segment_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [hsd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hsd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hsd_pkg::LevelW-1:0]    level_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    event_res_o,
  output logic [hsd_pkg::CountW-1:0]    piece_number_o,
  output logic [hsd_pkg::LenW-1:0]      span_length_o,
  output logic                          active_o
);
  import hsd_pkg::*;

  hsd_cfg_t cfg;
  hsd_res_t res;
  hsd_res_t res_q;

  logic              in_valid_q;
  logic [LevelW-1:0] level_q;
  logic              out_valid_q;
  logic              out_ready;
  logic              step_en;
  logic              in_accept;

  // Pipeline control
  assign out_ready = !out_valid_q || !out_stall_i;
  assign step_en = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept = in_valid_i && !in_stall_o;

  hsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hsd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .level_i   (level_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (out_ready) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      level_q <= level_i;
    end
  end

  // Result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = res_q.ev;
  assign piece_number_o = res_q.piece_number;
  assign span_length_o = res_q.span_length;
  assign active_o = res_q.active;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// Segment detector testbench
// Drives level words into the hysteresis segment detector under random
// sender gaps and receiver stalls, tracks piece state alongside the block and
// compares every result word field by field against the tracked prediction.
// Covers threshold edges, debounce limits at both extremes, register masking
// and alternating begin and end on every word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hsd_pkg::*;

  localparam int unsigned ClkHalf = 6;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned LongHold = 80;
  localparam int unsigned AlternateItems = 120;
  localparam int unsigned LongRun = 60;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems = 60;
  localparam int unsigned CycleLimit = 60000;
  localparam int unsigned ReportMax = 10;

  // Piece state kept alongside the block, one expected word per level word
  class piece_tracker;
    logic [LevelW-1:0] lvl_low;
    logic [LevelW-1:0] lvl_high;
    logic [MinRunW-1:0] min_low;
    logic [MinRunW-1:0] min_high;
    bit in_piece;
    logic [RunW-1:0] high_run;
    logic [RunW-1:0] low_run;
    logic [LenW-1:0] piece_len;
    logic [LenW-1:0] pause_len;
    logic [CountW-1:0] piece_count;
    hsd_res_t expected_words[$];
    int unsigned mismatch_count;

    function new();
      lvl_low = LevelLowRst;
      lvl_high = LevelHighRst;
      min_low = MinRunRst;
      min_high = MinRunRst;
      in_piece = 1'b0;
      high_run = '0;
      low_run = '0;
      piece_len = '0;
      pause_len = '0;
      piece_count = '0;
      mismatch_count = 0;
    endfunction

    // level registers keep only their low bits
    function void set_register(hsd_cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_LEVEL_LOW: lvl_low = data[LevelW-1:0];
        CFG_LEVEL_HIGH: lvl_high = data[LevelW-1:0];
        CFG_MIN_LOW_RUN: min_low = data;
        CFG_MIN_HIGH_RUN: min_high = data;
        default: ;
      endcase
    endfunction

    // Runs and lengths hold at all ones; the register ranges keep runs far
    // below that, and a length would need billions of words.
    function void take_level(logic [LevelW-1:0] lv);
      hsd_res_t res;
      res = '0;
      res.ev = EV_NONE;
      if (in_piece) begin
        if (lv <= lvl_low) begin
          if (low_run != '1) low_run = low_run + 1'b1;
        end else begin
          low_run = '0;
        end
        if (low_run > min_low) begin
          // low run leaves the piece and opens the pause, floor at zero
          pause_len = LenW'(low_run);
          piece_len = (piece_len > LenW'(low_run)) ? piece_len - LenW'(low_run) : '0;
          low_run = '0;
          in_piece = 1'b0;
          piece_count = piece_count + 1'b1;
          res.ev = EV_END;
          res.piece_number = piece_count;
          res.span_length = piece_len;
        end else if (piece_len != '1) begin
          piece_len = piece_len + 1'b1;
        end
      end else begin
        if (lv >= lvl_high) begin
          if (high_run != '1) high_run = high_run + 1'b1;
        end else begin
          high_run = '0;
        end
        if (high_run > min_high) begin
          // high run leaves the pause and opens the piece, floor at zero
          piece_len = LenW'(high_run);
          pause_len = (pause_len > LenW'(high_run)) ? pause_len - LenW'(high_run) : '0;
          high_run = '0;
          in_piece = 1'b1;
          res.ev = EV_BEGIN;
          res.piece_number = piece_count + 1'b1;
          res.span_length = pause_len;
        end else if (pause_len != '1) begin
          pause_len = pause_len + 1'b1;
        end
      end
      res.active = in_piece;
      expected_words.push_back(res);
    endfunction

    function void compare_result(logic [1:0] ev, logic [CountW-1:0] num,
                                 logic [LenW-1:0] span, logic act);
      hsd_res_t want;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("%0t: result word with nothing outstanding: %s%0d %0d %0d %0d",
                   $time, "ev/num/span/act=", ev, num, span, act);
      end else begin
        want = expected_words.pop_front();
        if (ev !== want.ev || num !== want.piece_number ||
            span !== want.span_length || act !== want.active) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax)
            $display("%0t: word mismatch: exp ev=%0d num=%0d span=%0d act=%0d,",
                     $time, want.ev, want.piece_number, want.span_length,
                     want.active, " got ev=%0d num=%0d span=%0d act=%0d",
                     ev, num, span, act);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  hsd_cfg_idx_e cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [LevelW-1:0] level_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [1:0] event_res_o;
  logic [CountW-1:0] piece_number_o;
  logic [LenW-1:0] span_length_o;
  logic active_o;

  piece_tracker tracker;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int unsigned cycle_count = 0;

  hysteresis_segment_detector u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .level_i        (level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .piece_number_o (piece_number_o),
    .span_length_o  (span_length_o),
    .active_o       (active_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Cycle budget; a hang or a lost word ends here
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Both channels sampled on pre-edge values
  always @(posedge clk_i) begin : word_monitor
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.take_level(level_i);
      if (out_valid_o && !out_stall_i)
        tracker.compare_result(event_res_o, piece_number_o, span_length_o, active_o);
    end
  end

  // Result sink: random stall bursts, plus one long hold on request
  initial begin : result_sink
    int unsigned burst;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
        burst = $urandom_range(1, 12);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // One register write; write enable is left high for the caller to drop
  task write_reg(input hsd_cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    tracker.set_register(idx, data);
  endtask

  task program_detector(input logic [CfgDataW-1:0] w_low, input logic [CfgDataW-1:0] w_high,
                        input logic [CfgDataW-1:0] w_min_low,
                        input logic [CfgDataW-1:0] w_min_high);
    write_reg(CFG_LEVEL_LOW, w_low);
    write_reg(CFG_LEVEL_HIGH, w_high);
    write_reg(CFG_MIN_LOW_RUN, w_min_low);
    write_reg(CFG_MIN_HIGH_RUN, w_min_high);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one level word, with an optional gap ahead of it
  task send_level(input logic [LevelW-1:0] lv);
    if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_i <= lv;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop sending and wait for every outstanding result word
  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random thresholds with junk above the level bits, short debounce mostly
  task random_setup();
    logic [CfgDataW-1:0] w_low;
    logic [CfgDataW-1:0] w_high;
    logic [LevelW-1:0] lo;
    logic [LevelW-1:0] hi;
    lo = LevelW'($urandom_range(0, 700));
    hi = LevelW'($urandom_range(lo, 1023));
    if ($urandom_range(0, 5) == 0) hi = LevelW'($urandom);
    w_low = CfgDataW'($urandom);
    w_low[LevelW-1:0] = lo;
    w_high = CfgDataW'($urandom);
    w_high[LevelW-1:0] = hi;
    program_detector(w_low, w_high,
                     CfgDataW'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 40 : 8)),
                     CfgDataW'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 40 : 8)));
  endtask

  // Mostly runs around the debounce limits, some mid band and plain noise
  task random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        len = tracker.min_high + $urandom_range(0, 2);
        repeat (len) send_level(LevelW'($urandom_range(tracker.lvl_high, 1023)));
      end else if (kind <= 7) begin
        len = tracker.min_low + $urandom_range(0, 2);
        repeat (len) send_level(LevelW'($urandom_range(0, tracker.lvl_low)));
      end else if (kind == 8 || tracker.lvl_high <= tracker.lvl_low + 1) begin
        len = $urandom_range(1, 6);
        repeat (len) send_level(LevelW'($urandom));
      end else begin
        len = $urandom_range(1, 4);
        repeat (len)
          send_level(LevelW'($urandom_range(tracker.lvl_low + 1, tracker.lvl_high - 1)));
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    int unsigned phase_no;
    tracker = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    level_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_LEVEL_LOW;
    cfg_wdata_i <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset thresholds: begin straight out of reset (pause floors at zero),
    // a near-miss above the low level, then an end after a run on the exact low level
    repeat (11) send_level(10'd1023);
    send_level(10'd101);
    repeat (10) send_level(10'd100);
    send_level(10'd0);
    send_level(10'd499);
    send_level(10'd500);
    drain();

    // Every word both high and low, no debounce: begin and end alternate
    program_detector(16'hFFFF, 16'hFC00, 16'h0000, 16'h0000);
    repeat (AlternateItems) send_level(LevelW'($urandom));
    drain();

    // Widest debounce on the tightest levels: long runs stay below the limit
    program_detector(16'h0000, 16'h03FF, 16'hFFFF, 16'hFFFF);
    repeat (LongRun) send_level(10'd1023);
    send_level(10'd512);
    repeat (LongRun) send_level(10'd0);
    drain();

    // Random settings; third phase holds the sink off while words keep coming,
    // last phase runs without any idling
    for (phase_no = 0; phase_no < RandomPhases; phase_no++) begin
      random_setup();
      tx_idle_pct = (phase_no == RandomPhases - 1) ? 0 : $urandom_range(0, 25);
      rx_idle_pct = (phase_no == RandomPhases - 1) ? 0 : $urandom_range(0, 15);
      if (phase_no == 2) begin
        tx_idle_pct = 0;
        hold_req = 1'b1;
        repeat (40) send_level(LevelW'($urandom));
        tx_idle_pct = $urandom_range(5, 25);
      end
      random_phase(PhaseItems);
      drain();
    end

    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
